// File: design/circular_event_log_cursor_defines.svh
// ---------------------------------------------------------------------------
// Circular event log cursor: assertion macros
// Shared assertion wrappers, clocked on the block clock.
// ---------------------------------------------------------------------------
`ifndef CIRCULAR_EVENT_LOG_CURSOR_DEFINES_SVH
`define CIRCULAR_EVENT_LOG_CURSOR_DEFINES_SVH

// Checked outside of reset only.
`define CELC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define CELC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: design/celc_pkg.sv
// ---------------------------------------------------------------------------
// Circular event log cursor: package
// Command and position codes, register map and payload types.
// ---------------------------------------------------------------------------
package celc_pkg;

   localparam logic [1:0] CMD_APPEND = 2'd0;
   localparam logic [1:0] CMD_CLEAR  = 2'd1;
   localparam logic [1:0] CMD_NEWER  = 2'd2;
   localparam logic [1:0] CMD_OLDER  = 2'd3;

   localparam logic [1:0] POS_OLDEST = 2'd0;
   localparam logic [1:0] POS_NEWEST = 2'd1;
   localparam logic [1:0] POS_MIDDLE = 2'd2;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic        REG_LIVE_FOLLOW = 1'b0;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [19:0] power_in;
      logic [15:0] voltage_in;
      logic [2:0]  type_in;
      logic [31:0] stamp_in;
   } req_type;

   typedef struct packed {
      logic        cursor_valid;
      logic [31:0] event_id;
      logic [1:0]  position;
      logic [4:0]  fill_count;
      logic [19:0] power_out;
      logic [15:0] voltage_out;
      logic [2:0]  type_out;
      logic [31:0] stamp_out;
      logic        edge_hit;
   } rsp_type;

   // One stored event as it sits in the ring memory.
   typedef struct packed {
      logic [31:0] event_id;
      logic [19:0] power;
      logic [15:0] voltage;
      logic [2:0]  ev_type;
      logic [31:0] stamp;
   } record_type;

   // Cursor status that travels with a request to the result stage.
   typedef struct packed {
      logic       cursor_valid;
      logic [1:0] position;
      logic [4:0] fill_count;
      logic       edge_hit;
   } meta_type;

endpackage

// File: design/celc_ram.sv
// ---------------------------------------------------------------------------
// Circular event log cursor: generic RAM
// One write port and one read port with a registered read.
// ---------------------------------------------------------------------------
module celc_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/celc_ctrl.sv
// ---------------------------------------------------------------------------
// Circular event log cursor: ring and cursor control
// Holds the ring pointers and the cursor, and works out one command a cycle while accept is high.
// ---------------------------------------------------------------------------
module celc_ctrl
   import celc_pkg::*;
#(
   parameter int unsigned EVENTS = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       accept,
   input  logic [1:0]                                 cmd,
   input  logic                                       live_follow,
   output logic                                       wr_en,
   output logic [(EVENTS > 1 ? $clog2(EVENTS) : 1)-1:0] wr_slot,
   output logic [(EVENTS > 1 ? $clog2(EVENTS) : 1)-1:0] rd_slot,
   output meta_type                                   meta
);

   localparam int unsigned SW   = (EVENTS > 1) ? $clog2(EVENTS) : 1;
   localparam int unsigned CW   = $clog2(EVENTS + 1);
   localparam int unsigned SUMW = CW + 1;
   localparam logic [SW-1:0]   LAST_SLOT  = SW'(EVENTS - 1);
   localparam logic [CW-1:0]   CNT_EVENTS = CW'(EVENTS);
   localparam logic [SUMW-1:0] SUM_EVENTS = SUMW'(EVENTS);
   localparam bit              SINGLE     = (EVENTS == 1);

   logic [SW-1:0] oldest_ff, oldest_in;
   logic [CW-1:0] total_ff, total_in;
   logic [SW-1:0] cursor_ff, cursor_in;
   logic          cset_ff, cset_in;

   logic          full;
   logic          take;
   logic [SW-1:0] ap_oldest, ap_cursor, ap_slot;
   logic [CW-1:0] ap_total;
   logic          ap_cset;
   logic [SW-1:0] cur_newest, nxt_newest;
   logic          edge_flag;

   function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
      return (s == LAST_SLOT) ? '0 : SW'(s + 1'b1);
   endfunction

   function automatic logic [SW-1:0] slot_dec(input logic [SW-1:0] s);
      return (s == '0) ? LAST_SLOT : SW'(s - 1'b1);
   endfunction

   // Slot that follows the newest entry: oldest plus count, folded into the ring.
   function automatic logic [SW-1:0] slot_after(input logic [SW-1:0] o,
                                                input logic [CW-1:0] t);
      logic [SUMW-1:0] sum;
      sum = SUMW'(o) + SUMW'(t);
      return (sum >= SUM_EVENTS) ? SW'(sum - SUM_EVENTS) : SW'(sum);
   endfunction

   // Append: evict the oldest entry when full, then place the new one.
   always_comb begin
      full      = (total_ff == CNT_EVENTS);
      ap_oldest = full ? slot_inc(oldest_ff) : oldest_ff;
      ap_total  = full ? CW'(total_ff - 1'b1) : total_ff;
      ap_cursor = cursor_ff;
      ap_cset   = cset_ff;
      if (full && cset_ff && (cursor_ff == oldest_ff)) begin
         if (SINGLE) begin
            ap_cset = 1'b0;
         end else begin
            ap_cursor = slot_inc(oldest_ff);
         end
      end
      ap_slot = slot_after(ap_oldest, ap_total);
      take    = ((ap_total == '0) && !ap_cset) || live_follow;
      if (take) begin
         ap_cursor = ap_slot;
         ap_cset   = 1'b1;
      end
      ap_total = CW'(ap_total + 1'b1);
   end

   assign cur_newest = slot_dec(slot_after(oldest_ff, total_ff));

   always_comb begin
      oldest_in = oldest_ff;
      total_in  = total_ff;
      cursor_in = cursor_ff;
      cset_in   = cset_ff;
      edge_flag = 1'b0;
      unique case (cmd)
         CMD_APPEND: begin
            oldest_in = ap_oldest;
            total_in  = ap_total;
            cursor_in = ap_cursor;
            cset_in   = ap_cset;
         end
         CMD_CLEAR: begin
            oldest_in = '0;
            total_in  = '0;
            cursor_in = '0;
            cset_in   = 1'b0;
         end
         CMD_NEWER: begin
            if (cset_ff && (total_ff != '0) && (cursor_ff != cur_newest)) begin
               cursor_in = slot_inc(cursor_ff);
            end else begin
               edge_flag = 1'b1;
            end
         end
         CMD_OLDER: begin
            if (cset_ff && (total_ff != '0) && (cursor_ff != oldest_ff)) begin
               cursor_in = slot_dec(cursor_ff);
            end else begin
               edge_flag = 1'b1;
            end
         end
         default: begin
            edge_flag = 1'b0;
         end
      endcase
   end

   // Position of the cursor within the ring after the command.
   assign nxt_newest = slot_dec(slot_after(oldest_in, total_in));

   always_comb begin
      meta.cursor_valid = cset_in && (total_in != '0);
      meta.fill_count   = 5'(total_in);
      meta.edge_hit     = edge_flag;
      if (cursor_in == oldest_in) begin
         meta.position = POS_OLDEST;
      end else if (cursor_in == nxt_newest) begin
         meta.position = POS_NEWEST;
      end else begin
         meta.position = POS_MIDDLE;
      end
   end

   assign wr_en   = accept && (cmd == CMD_APPEND);
   assign wr_slot = ap_slot;
   assign rd_slot = cursor_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff <= '0;
         total_ff  <= '0;
         cursor_ff <= '0;
         cset_ff   <= 1'b0;
      end else if (accept) begin
         oldest_ff <= oldest_in;
         total_ff  <= total_in;
         cursor_ff <= cursor_in;
         cset_ff   <= cset_in;
      end
   end

endmodule

// File: design/circular_event_log_cursor.sv
// ---------------------------------------------------------------------------
// Circular event log cursor
// A ring of EVENTS event records with a sequence id stamp per append, oldest
// eviction when full, and a viewing cursor that answers every request.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                  Payload
//   req_      in         req_valid / req_ready      req_type (command and event data)
//   rsp_      out        rsp_valid / rsp_ready      rsp_type (cursor record and status)
//   APB       in         psel / penable / pready    live_follow at byte address 0
//
// Each request is registered into the result register, and a new request
// can be accepted in every cycle unless the result is stalled. The rate is one
// request per cycle, set by the single write and read ports of the record memory.
// Reset is synchronous and active high; it empties the log, parks the cursor,
// restarts the id counter at 1 and clears live_follow. The record memory itself
// is not cleared, because the cursor never points at a slot that was not written.
// When the result is stalled, the request channel stalls with it in the same cycle.
//
`include "circular_event_log_cursor_defines.svh"

module circular_event_log_cursor
   import celc_pkg::*;
#(
   parameter int unsigned EVENTS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   // Result channel.
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   // Configuration port.
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int unsigned SW = (EVENTS > 1) ? $clog2(EVENTS) : 1;

   // The register index is the word address, so the low byte-offset bits are ignored.
   logic          live_follow_ff;
   logic          csr_write;

   logic          accept;
   logic          wr_en;
   logic [SW-1:0] wr_slot;
   logic [SW-1:0] rd_slot;
   meta_type      meta;

   logic [31:0]   next_seq_ff;
   record_type    wr_rec;
   record_type    rd_rec;
   record_type    view_rec;

   // Result stage.
   logic          rsp_valid_ff;
   meta_type      meta_ff;
   logic          byp_hit_ff;
   record_type    byp_rec_ff;

   // ------------------------------------------------------------------
   // Configuration. Users must issue writes only while the log is quiet; not enforced.
   // ------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr[2] == REG_LIVE_FOLLOW);

   always_ff @(posedge clock) begin
      if (reset) begin
         live_follow_ff <= 1'b0;
      end else if (csr_write) begin
         live_follow_ff <= pwdata[0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_LIVE_FOLLOW) begin
         prdata[0] = live_follow_ff;
      end
   end

   // ------------------------------------------------------------------
   // Handshake. The result register frees up in the same cycle it is taken,
   // so requests flow at full rate as long as the consumer keeps up.
   // ------------------------------------------------------------------
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // ------------------------------------------------------------------
   // Pointer and cursor control: decides the write slot for an append and
   // the slot the cursor rests on after the request.
   // ------------------------------------------------------------------
   celc_ctrl #(
      .EVENTS (EVENTS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .cmd         (req_data.cmd),
      .live_follow (live_follow_ff),
      .wr_en       (wr_en),
      .wr_slot     (wr_slot),
      .rd_slot     (rd_slot),
      .meta        (meta)
   );

   // The sequence id counter survives a clear and wraps through zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         next_seq_ff <= 32'd1;
      end else if (wr_en) begin
         next_seq_ff <= next_seq_ff + 32'd1;
      end
   end

   always_comb begin
      wr_rec.event_id = next_seq_ff;
      wr_rec.power    = req_data.power_in;
      wr_rec.voltage  = req_data.voltage_in;
      wr_rec.ev_type  = req_data.type_in;
      wr_rec.stamp    = req_data.stamp_in;
   end

   // ------------------------------------------------------------------
   // Record memory. The cursor slot is read in the same cycle the request
   // is accepted; the read data is held while the result is stalled.
   // ------------------------------------------------------------------
   celc_ram #(
      .WIDTH ($bits(record_type)),
      .DEPTH (EVENTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_slot),
      .wr_data (wr_rec),
      .rd_en   (accept),
      .rd_addr (rd_slot),
      .rd_data (rd_rec)
   );

   // When the cursor lands on the slot being written, the new record is
   // forwarded around the memory instead of reading the slot's old contents.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ready) begin
         rsp_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         meta_ff    <= meta;
         byp_hit_ff <= wr_en && (wr_slot == rd_slot);
         byp_rec_ff <= wr_rec;
      end
   end

   assign view_rec = byp_hit_ff ? byp_rec_ff : rd_rec;

   // An empty log reports zeros in every record field.
   always_comb begin
      rsp_data              = '0;
      rsp_data.cursor_valid = meta_ff.cursor_valid;
      rsp_data.fill_count   = meta_ff.fill_count;
      rsp_data.edge_hit     = meta_ff.edge_hit;
      if (meta_ff.cursor_valid) begin
         rsp_data.event_id    = view_rec.event_id;
         rsp_data.position    = meta_ff.position;
         rsp_data.power_out   = view_rec.power;
         rsp_data.voltage_out = view_rec.voltage;
         rsp_data.type_out    = view_rec.ev_type;
         rsp_data.stamp_out   = view_rec.stamp;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   `CELC_ASSERT(a_clear_empties, (accept && (req_data.cmd == CMD_CLEAR)) |=> (rsp_valid && !rsp_data.cursor_valid && (rsp_data.fill_count == 5'd0)), "clear did not empty the log")
   `CELC_ASSERT(a_no_edge_on_write, (accept && ((req_data.cmd == CMD_APPEND) || (req_data.cmd == CMD_CLEAR))) |=> !rsp_data.edge_hit, "edge flagged on append or clear")
   `CELC_ASSERT(a_live_at_newest, (accept && live_follow_ff && (req_data.cmd == CMD_APPEND)) |=> (rsp_data.cursor_valid && (rsp_data.position != POS_MIDDLE)), "live cursor not on newest entry")
   `CELC_ASSERT_ALWAYS(a_ready_when_free, !rsp_valid |-> req_ready, "request stalled with an empty result stage")

endmodule
